// File: hdl/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg: shared types and constants of the cartridge bank mapper
// Holds the item kinds, the CPU register decode, the bank register selects,
// the configuration indexes and the bank clamp function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cbm_pkg;

    // Kinds of input items.
    localparam logic [2:0] KIND_CPU_WRITE   = 3'd0;
    localparam logic [2:0] KIND_CPU_TICK    = 3'd1;
    localparam logic [2:0] KIND_LINE12      = 3'd2;
    localparam logic [2:0] KIND_CPU_QUERY   = 3'd3;
    localparam logic [2:0] KIND_VIDEO_QUERY = 3'd4;

    // CPU register decode: address bits 15:12 and 0 pick the register.
    localparam logic [15:0] CPU_ADDR_MASK    = 16'hF001;
    localparam logic [15:0] REG_BANK_SELECT  = 16'h8000;
    localparam logic [15:0] REG_BANK_DATA    = 16'h8001;
    localparam logic [15:0] REG_MIRROR       = 16'hA000;
    localparam logic [15:0] REG_IRQ_LATCH    = 16'hC000;
    localparam logic [15:0] REG_IRQ_RELOAD   = 16'hC001;
    localparam logic [15:0] REG_IRQ_DISABLE  = 16'hE000;
    localparam logic [15:0] REG_IRQ_ENABLE   = 16'hE001;

    // Bank register selects written through the bank data register.
    localparam logic [3:0] SEL_CHR_2K_0 = 4'd0;
    localparam logic [3:0] SEL_CHR_2K_1 = 4'd1;
    localparam logic [3:0] SEL_CHR_1K_0 = 4'd2;
    localparam logic [3:0] SEL_CHR_1K_1 = 4'd3;
    localparam logic [3:0] SEL_CHR_1K_2 = 4'd4;
    localparam logic [3:0] SEL_CHR_1K_3 = 4'd5;
    localparam logic [3:0] SEL_PRG_0    = 4'd6;
    localparam logic [3:0] SEL_PRG_1    = 4'd7;
    localparam logic [3:0] SEL_CHR_1K_4 = 4'd8;
    localparam logic [3:0] SEL_CHR_1K_5 = 4'd9;
    localparam logic [3:0] SEL_PRG_2    = 4'd15;

    // Configuration register indexes.
    localparam logic [1:0] CFG_VARIANT       = 2'd0;
    localparam logic [1:0] CFG_PRG_BANK_LAST = 2'd1;
    localparam logic [1:0] CFG_CHR_BANK_LAST = 2'd2;

    // The 8K program slot at 0xE000 always maps the last bank.
    localparam logic [1:0] PRG_SLOT_FIXED = 2'd3;

    // CPU ticks between the counter firing and the IRQ line rising.
    localparam logic [1:0] FIRE_DELAY_CYCLES = 2'd3;

    typedef struct packed {
        logic       variant;
        logic [7:0] prg_bank_last;
        logic [7:0] chr_bank_last;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] address;
        logic [7:0]  data;
    } t_item;

    typedef struct packed {
        logic [7:0][7:0] pattern_regs;
        logic [2:0][7:0] program_regs;
        logic            program_swap;
        logic [1:0]      pattern_mode;
        logic            mirror_horizontal;
        logic [3:0]      nametable_select;
    } t_bank_state;

    // A bank above its limit is masked with the limit.
    function automatic logic [7:0] clamp_bank(input logic [7:0] v, input logic [7:0] limit);
        clamp_bank = (v > limit) ? (v & limit) : v;
    endfunction

endpackage

`default_nettype wire

// File: hdl/cartridge_bank_mapper_with_irq_counter.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_irq_counter: console cartridge bank mapper
// Input register, register file, IRQ counter, lookup logic and result
// register for a bank switching cartridge mapper.
// ----------------------------------------------------------------------------
// Usage:
// Each input transaction (i_kind, i_address, i_data) is a CPU register write,
// a CPU cycle tick, a video clock on line 12, a CPU bank query or a video query.
// Every input transaction produces exactly one output transaction carrying
// the mapped bank (zero unless the item is a query), the nametable page and
// the IRQ line as it stands after the item has been applied.
// An item is captured in the input register, then applied to the state and
// looked up into the result register. One item is taken per cycle as long as
// the output is not stalled.
// When the receiver asserts i_out_stall the result register holds; the input
// register keeps absorbing one more item, and o_in_stall rises only when both
// stages are full and the output is stalled.
// The configuration channel (variant, last program bank, last pattern bank)
// is always ready and must be written only while the block is idle.
// Synchronous reset loads the power-on bank registers, vertical mirroring,
// CPU cycle counting mode and an empty pipeline; there is no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cartridge_bank_mapper_with_irq_counter (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input channel
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [2:0]  i_kind,
    input  wire  [15:0] i_address,
    input  wire  [7:0]  i_data,
    // output channel
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [7:0]  o_bank,
    output logic        o_nametable_page,
    output logic        o_irq_line,
    // configuration channel
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [7:0]  i_cfg_data
);

    // Configuration registers.
    cbm_pkg::t_cfg r_cfg;

    // Input register stage.
    logic           r_in_valid;
    cbm_pkg::t_item r_item;

    // Result register stage.
    logic       r_out_valid;
    logic [7:0] r_bank;
    logic       r_page;
    logic       r_irq;

    logic                 w_advance;
    logic                 w_in_accept;
    cbm_pkg::t_bank_state w_state;
    logic [7:0]           w_bank;
    logic                 w_page;
    logic                 w_irq_next;

    // The item in the input register is applied when the result register
    // is free or is being emptied in this cycle.
    assign w_advance   = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_advance;
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.variant       <= 1'b0;
            r_cfg.prg_bank_last <= 8'd15;
            r_cfg.chr_bank_last <= 8'd255;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                cbm_pkg::CFG_VARIANT:       r_cfg.variant       <= i_cfg_data[0];
                cbm_pkg::CFG_PRG_BANK_LAST: r_cfg.prg_bank_last <= i_cfg_data;
                cbm_pkg::CFG_CHR_BANK_LAST: r_cfg.chr_bank_last <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_item.kind    <= i_kind;
            r_item.address <= i_address;
            r_item.data    <= i_data;
        end
    end

    cbm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_advance),
        .i_item  (r_item),
        .i_cfg   (r_cfg),
        .o_state (w_state)
    );

    cbm_irq u_irq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_advance),
        .i_item     (r_item),
        .o_irq_next (w_irq_next)
    );

    // The lookup sees the state before this item, as a query does not
    // change it and a write never produces a bank.
    cbm_query u_query (
        .i_item           (r_item),
        .i_cfg            (r_cfg),
        .i_state          (w_state),
        .o_bank           (w_bank),
        .o_nametable_page (w_page)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_bank <= w_bank;
            r_page <= w_page;
            r_irq  <= w_irq_next;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_bank           = r_bank;
    assign o_nametable_page = r_page;
    assign o_irq_line       = r_irq;

endmodule

`default_nettype wire

// File: hdl/cbm_regs.sv
// ----------------------------------------------------------------------------
// cbm_regs: bank, mode and mirroring registers
// Decodes CPU writes to the bank select, bank data and mirroring registers
// and holds the resulting bank state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbm_regs (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_step,
    input  cbm_pkg::t_item      i_item,
    input  cbm_pkg::t_cfg       i_cfg,
    output cbm_pkg::t_bank_state o_state
);

    cbm_pkg::t_bank_state r_state, n_state;
    logic [3:0]           r_select, n_select;
    logic                 w_page;
    logic [7:0]           w_clamp_1k;
    logic [7:0]           w_clamp_prg;

    assign w_page      = ~i_item.data[7];
    assign w_clamp_1k  = cbm_pkg::clamp_bank(i_item.data, i_cfg.chr_bank_last);
    assign w_clamp_prg = cbm_pkg::clamp_bank(i_item.data, i_cfg.prg_bank_last);

    always_comb begin
        n_state  = r_state;
        n_select = r_select;
        if (i_step && (i_item.kind == cbm_pkg::KIND_CPU_WRITE)) begin
            case (i_item.address & cbm_pkg::CPU_ADDR_MASK)
                cbm_pkg::REG_BANK_SELECT: begin
                    n_select             = i_item.data[3:0];
                    n_state.program_swap = i_item.data[6];
                    n_state.pattern_mode = {i_item.data[7], i_item.data[5]};
                end
                cbm_pkg::REG_BANK_DATA: begin
                    case (r_select)
                        cbm_pkg::SEL_CHR_2K_0, cbm_pkg::SEL_CHR_2K_1: begin
                            if (i_cfg.variant && !r_state.pattern_mode[1]) begin
                                n_state.nametable_select[{r_select[0], 1'b0}] = w_page;
                                n_state.nametable_select[{r_select[0], 1'b1}] = w_page;
                            end
                            n_state.pattern_regs[r_select[2:0]] = i_item.data;
                        end
                        cbm_pkg::SEL_CHR_1K_0, cbm_pkg::SEL_CHR_1K_1,
                        cbm_pkg::SEL_CHR_1K_2, cbm_pkg::SEL_CHR_1K_3: begin
                            if (i_cfg.variant && r_state.pattern_mode[1]) begin
                                // Selects 2..5 map onto nametable quarters 0..3.
                                n_state.nametable_select[r_select[1:0] ^ 2'b10] = w_page;
                            end
                            n_state.pattern_regs[r_select[2:0]] = w_clamp_1k;
                        end
                        cbm_pkg::SEL_PRG_0, cbm_pkg::SEL_PRG_1: begin
                            n_state.program_regs[{1'b0, r_select[0]}] = w_clamp_prg;
                        end
                        cbm_pkg::SEL_CHR_1K_4, cbm_pkg::SEL_CHR_1K_5: begin
                            n_state.pattern_regs[{2'b11, r_select[0]}] = w_clamp_1k;
                        end
                        cbm_pkg::SEL_PRG_2: begin
                            n_state.program_regs[2] = w_clamp_prg;
                        end
                        default: begin
                        end
                    endcase
                end
                cbm_pkg::REG_MIRROR: begin
                    if (!i_cfg.variant) begin
                        n_state.mirror_horizontal = i_item.data[0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_state.pattern_regs[i] <= 8'(i);
            end
            for (int i = 0; i < 3; i++) begin
                r_state.program_regs[i] <= 8'(i);
            end
            r_state.program_swap      <= 1'b0;
            r_state.pattern_mode      <= 2'd0;
            r_state.mirror_horizontal <= 1'b0;
            r_state.nametable_select  <= 4'd0;
            r_select                  <= 4'd0;
        end else begin
            r_state  <= n_state;
            r_select <= n_select;
        end
    end

    assign o_state = r_state;

endmodule

`default_nettype wire

// File: hdl/cbm_irq.sv
// ----------------------------------------------------------------------------
// cbm_irq: IRQ counter
// Scanline or prescaled CPU cycle counter with reload latch, a fire delay
// counted in CPU ticks and the IRQ request flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbm_irq (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_step,
    input  cbm_pkg::t_item i_item,
    output logic           o_irq_next
);

    logic       r_count_cpu, n_count_cpu;
    logic [1:0] r_prescale, n_prescale;
    logic [1:0] r_fire_delay, n_fire_delay;
    logic [7:0] r_count, n_count;
    logic [7:0] r_latch, n_latch;
    logic       r_reload, n_reload;
    logic       r_enabled, n_enabled;
    logic       r_prior_nonzero, n_prior_nonzero;
    logic       r_asserted, n_asserted;

    always_comb begin
        n_count_cpu     = r_count_cpu;
        n_prescale      = r_prescale;
        n_fire_delay    = r_fire_delay;
        n_count         = r_count;
        n_latch         = r_latch;
        n_reload        = r_reload;
        n_enabled       = r_enabled;
        n_prior_nonzero = r_prior_nonzero;
        n_asserted      = r_asserted;
        if (i_step) begin
            case (i_item.kind)
                cbm_pkg::KIND_CPU_WRITE: begin
                    case (i_item.address & cbm_pkg::CPU_ADDR_MASK)
                        cbm_pkg::REG_IRQ_LATCH: begin
                            n_latch = i_item.data;
                        end
                        cbm_pkg::REG_IRQ_RELOAD: begin
                            n_reload = 1'b1;
                            if (i_item.data[0]) begin
                                n_count_cpu = 1'b1;
                                n_prescale  = 2'd0;
                            end else begin
                                n_count_cpu = 1'b0;
                                n_count     = 8'd0;
                            end
                        end
                        cbm_pkg::REG_IRQ_DISABLE: begin
                            n_enabled  = 1'b0;
                            n_asserted = 1'b0;
                        end
                        cbm_pkg::REG_IRQ_ENABLE: begin
                            n_enabled = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
                cbm_pkg::KIND_CPU_TICK: begin
                    // A running delay counts down even after a disable.
                    if (r_fire_delay != 2'd0) begin
                        n_fire_delay = r_fire_delay - 2'd1;
                        if (r_fire_delay == 2'd1) begin
                            n_asserted = 1'b1;
                        end
                    end
                    if (r_count_cpu) begin
                        if (r_prescale != 2'd3) begin
                            n_prescale = r_prescale + 2'd1;
                        end else begin
                            n_prescale = 2'd0;
                            if (r_reload) begin
                                n_count  = r_latch + 8'd1;
                                n_reload = 1'b0;
                            end else if (r_count != 8'd0) begin
                                n_count = r_count - 8'd1;
                                if ((r_count == 8'd1) && r_enabled) begin
                                    n_fire_delay = cbm_pkg::FIRE_DELAY_CYCLES;
                                end
                            end else begin
                                n_count = r_latch;
                            end
                        end
                    end
                end
                cbm_pkg::KIND_LINE12: begin
                    if (!r_count_cpu) begin
                        if (r_count == 8'd0) begin
                            n_count = r_latch;
                            if (r_reload) begin
                                n_count         = r_latch + 8'd1;
                                n_prior_nonzero = 1'b0;
                            end
                            if ((n_count == 8'd0) && r_reload) begin
                                n_prior_nonzero = 1'b1;
                            end
                            n_reload = 1'b0;
                        end else begin
                            n_count = r_count - 8'd1;
                        end
                        if ((n_count == 8'd0) && n_prior_nonzero && r_enabled) begin
                            n_fire_delay = cbm_pkg::FIRE_DELAY_CYCLES;
                        end
                        n_prior_nonzero = (n_count != 8'd0);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_cpu     <= 1'b1;
            r_prescale      <= 2'd0;
            r_fire_delay    <= 2'd0;
            r_count         <= 8'd0;
            r_latch         <= 8'd0;
            r_reload        <= 1'b0;
            r_enabled       <= 1'b0;
            r_prior_nonzero <= 1'b0;
            r_asserted      <= 1'b0;
        end else begin
            r_count_cpu     <= n_count_cpu;
            r_prescale      <= n_prescale;
            r_fire_delay    <= n_fire_delay;
            r_count         <= n_count;
            r_latch         <= n_latch;
            r_reload        <= n_reload;
            r_enabled       <= n_enabled;
            r_prior_nonzero <= n_prior_nonzero;
            r_asserted      <= n_asserted;
        end
    end

    assign o_irq_next = n_asserted;

endmodule

`default_nettype wire

// File: hdl/cbm_query.sv
// ----------------------------------------------------------------------------
// cbm_query: bank and nametable lookup
// Maps a CPU address to an 8K program bank and a video address to a 1K
// pattern bank or a nametable page.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbm_query (
    input  cbm_pkg::t_item       i_item,
    input  cbm_pkg::t_cfg        i_cfg,
    input  cbm_pkg::t_bank_state i_state,
    output logic [7:0]           o_bank,
    output logic                 o_nametable_page
);

    logic [1:0] w_prg_slot;
    logic [7:0] w_prg_bank;
    logic [2:0] w_chr_slot;
    logic [1:0] w_quarter;
    logic [6:0] w_limit_2k;
    logic [6:0] w_half_bank;
    logic [7:0] w_chr_bank;
    logic       w_page;

    assign w_prg_slot = i_item.address[14:13];
    assign w_chr_slot = i_item.address[12:10];
    assign w_quarter  = i_item.address[11:10];

    // Highest 2K bank; unused when the 1K limit is zero.
    assign w_limit_2k  = 7'((i_cfg.chr_bank_last - 8'd1) >> 1);

    always_comb begin
        logic [7:0] v;
        v = {1'b0, i_state.pattern_regs[w_chr_slot[1]][7:1]};
        if (i_cfg.chr_bank_last != 8'd0) begin
            v = cbm_pkg::clamp_bank(v, {1'b0, w_limit_2k});
        end
        w_half_bank = v[6:0];
    end

    always_comb begin
        if (w_prg_slot == cbm_pkg::PRG_SLOT_FIXED) begin
            w_prg_bank = i_cfg.prg_bank_last;
        end else if (i_state.program_swap) begin
            case (w_prg_slot)
                2'd0:    w_prg_bank = i_state.program_regs[2];
                2'd1:    w_prg_bank = i_state.program_regs[0];
                default: w_prg_bank = i_state.program_regs[1];
            endcase
        end else begin
            w_prg_bank = i_state.program_regs[w_prg_slot];
        end
    end

    always_comb begin
        if (w_chr_slot[2] != i_state.pattern_mode[1]) begin
            // The four 1K registers fill the half picked by the inversion bit.
            w_chr_bank = i_state.pattern_regs[{1'b0, w_chr_slot[1:0]} + 3'd2];
        end else if (i_state.pattern_mode[0]) begin
            case (w_chr_slot[1:0])
                2'd0:    w_chr_bank = cbm_pkg::clamp_bank(i_state.pattern_regs[0],
                                                          i_cfg.chr_bank_last);
                2'd1:    w_chr_bank = i_state.pattern_regs[6];
                2'd2:    w_chr_bank = cbm_pkg::clamp_bank(i_state.pattern_regs[1],
                                                          i_cfg.chr_bank_last);
                default: w_chr_bank = i_state.pattern_regs[7];
            endcase
        end else begin
            w_chr_bank = {w_half_bank, w_chr_slot[0]};
        end
    end

    always_comb begin
        if (i_cfg.variant) begin
            w_page = i_state.nametable_select[w_quarter];
        end else if (i_state.mirror_horizontal) begin
            w_page = w_quarter[1];
        end else begin
            w_page = w_quarter[0];
        end
    end

    always_comb begin
        o_bank           = 8'd0;
        o_nametable_page = 1'b0;
        case (i_item.kind)
            cbm_pkg::KIND_CPU_QUERY: begin
                if (i_item.address[15]) begin
                    o_bank = w_prg_bank;
                end
            end
            cbm_pkg::KIND_VIDEO_QUERY: begin
                if (!i_item.address[13]) begin
                    o_bank = w_chr_bank;
                end else begin
                    o_nametable_page = w_page;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/cbm_checker.sv
// ----------------------------------------------------------------------------
// cbm_port_checks: port level checks for the cartridge bank mapper
// Watches the top level ports and is attached to it by a bind statement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbm_port_checks (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_in_stall,
    input wire        o_out_valid,
    input wire        i_out_stall,
    input wire [7:0]  o_bank,
    input wire        o_nametable_page,
    input wire        o_irq_line
);

    // The input side backs up only behind a stalled, full result register.
    a_stall_needs_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while the output side can move");

    // A nametable page is only given by a video query, which has no bank.
    a_page_has_no_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_nametable_page) |-> (o_bank == 8'd0))
        else $error("nametable page reported together with a bank");

    // Reset empties the pipeline.
    a_reset_empties: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_bank) && $stable(o_nametable_page)
             && $stable(o_irq_line)))
        else $error("stalled result changed");

endmodule

bind cartridge_bank_mapper_with_irq_counter cbm_port_checks u_port_checks (.*);

`default_nettype wire
